// File: hw/rtl/tsc_pkg.sv
// Transient shaper package: sizes, register indexes, request structs, gain table.
// No dependencies; imported by every module of the shaper except tsc_ram.
`default_nettype none
package tsc_pkg;

  localparam int unsigned MaxChannels   = 2;
  localparam int unsigned GainTableBits = 8;

  localparam int unsigned ChW       = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned SampleW   = 24;
  localparam int unsigned CoeffW    = 24;
  localparam int unsigned AmtW      = 7;
  localparam int unsigned LevelW    = 48;
  localparam int unsigned RamW      = 2 * LevelW;
  localparam int unsigned QW        = 17;
  localparam int unsigned DivSteps  = 16;
  localparam int unsigned DivCntW   = $clog2(DivSteps);
  localparam int unsigned MixW      = 24;
  localparam int unsigned Mix3W     = 26;
  localparam int unsigned DbW       = 21;
  localparam int unsigned VW        = DbW + GainTableBits - 19 + 1;
  localparam int unsigned GainW     = 20;
  localparam int unsigned IdxW      = GainTableBits + 1;
  localparam int unsigned GainEntries = (1 << GainTableBits) + 1;
  localparam int unsigned CfgAddrW  = 3;

  localparam logic [CfgAddrW-1:0] RegFastAtk = 3'd0;
  localparam logic [CfgAddrW-1:0] RegFastRel = 3'd1;
  localparam logic [CfgAddrW-1:0] RegSlowAtk = 3'd2;
  localparam logic [CfgAddrW-1:0] RegSlowRel = 3'd3;
  localparam logic [CfgAddrW-1:0] RegAtkAmt  = 3'd4;
  localparam logic [CfgAddrW-1:0] RegSusAmt  = 3'd5;

  localparam logic [CoeffW-1:0] FastAtkRst = 24'd684500;
  localparam logic [CoeffW-1:0] FastRelRst = 24'd69760;
  localparam logic [CoeffW-1:0] SlowAtkRst = 24'd34913;
  localparam logic [CoeffW-1:0] SlowRelRst = 24'd1748;
  localparam logic [AmtW-1:0]   AmtMax     = 7'd100;

  localparam logic [LevelW-1:0] FloorQ47   = 48'd14073748836;
  localparam logic [31:0]       Recip25    = 32'd171798691;
  localparam logic [15:0]       Recip3     = 16'd43691;
  localparam logic [QW-1:0]     OneQ16     = 17'h10000;

  localparam longint unsigned Ln10Q28 = 64'd618095479;
  localparam longint unsigned OneQ28  = 64'd268435456;

  typedef struct packed {
    logic [CoeffW-1:0] fast_atk;
    logic [CoeffW-1:0] fast_rel;
    logic [CoeffW-1:0] slow_atk;
    logic [CoeffW-1:0] slow_rel;
  } env_coeff_t;

  typedef struct packed {
    logic              start;
    logic [SampleW-1:0] mag;
    logic [LevelW-1:0] fast;
    logic [LevelW-1:0] slow;
  } env_req_t;

  typedef struct packed {
    logic              start;
    logic [LevelW-1:0] num;
    logic [LevelW-1:0] den;
  } div_req_t;

  typedef logic [GainW-1:0] gain_tab_t [GainEntries];

  // shift-subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // 10^(dB/20) by truncated Taylor series in Q.28, rounded to Q4.16
  function automatic logic [GainW-1:0] gain_entry(input int unsigned k);
    longint unsigned z;
    longint unsigned sum;
    longint unsigned term;
    z    = udiv64(longint'(k) * 64'd6 * Ln10Q28, 64'd5 << GainTableBits);
    sum  = OneQ28;
    term = OneQ28;
    for (int n = 1; n <= 40; n++) begin
      term = udiv64((term * z) >> 28, longint'(n));
      if (term == 0) break;
      sum = sum + term;
    end
    return GainW'((sum + 64'd2048) >> 12);
  endfunction

  function automatic gain_tab_t build_gain_table();
    gain_tab_t t;
    for (int unsigned k = 0; k < GainEntries; k++) t[k] = gain_entry(k);
    return t;
  endfunction

  localparam gain_tab_t GainTable = build_gain_table();

endpackage
`default_nettype wire

// File: hw/rtl/tsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/tsc_env.sv
// Envelope update: fast and slow one-pole followers through one 24x24 multiplier.
// Depends on tsc_pkg.
`default_nettype none
module tsc_env import tsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  env_req_t          req_i,
  input  env_coeff_t        coeff_i,
  output logic              done_o,
  output logic [LevelW-1:0] fast_o,
  output logic [LevelW-1:0] slow_o
);

  logic              busy_q, prod_vld_q, done_q;
  logic [2:0]        cnt_q;
  logic [LevelW-1:0] fast_q, slow_q, target_q, acc_q, prod_q;
  logic              prod_lo_q, prod_slow_q, prod_up_q;

  logic              up;
  logic [LevelW-1:0] level, d, step, acc_level, new_level;
  logic [CoeffW-1:0] coeff, opnd;

  always_comb begin
    level     = cnt_q[1] ? slow_q : fast_q;
    up        = target_q > level;
    d         = up ? (target_q - level) : (level - target_q);
    if (cnt_q[1]) coeff = up ? coeff_i.slow_atk : coeff_i.slow_rel;
    else          coeff = up ? coeff_i.fast_atk : coeff_i.fast_rel;
    opnd      = cnt_q[0] ? d[CoeffW-1:0] : d[LevelW-1:CoeffW];
    step      = acc_q + {{CoeffW{1'b0}}, prod_q[LevelW-1:CoeffW]};
    acc_level = prod_slow_q ? slow_q : fast_q;
    new_level = prod_up_q ? (acc_level + step) : (acc_level - step);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd4);
      if (req_i.start) begin
        busy_q     <= 1'b1;
        cnt_q      <= '0;
        prod_vld_q <= 1'b0;
      end else if (busy_q) begin
        prod_vld_q <= (cnt_q != 3'd4);
        if (cnt_q == 3'd4) busy_q <= 1'b0;
        else               cnt_q  <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      fast_q   <= req_i.fast;
      slow_q   <= req_i.slow;
      target_q <= {req_i.mag, {CoeffW{1'b0}}};
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        prod_q      <= coeff * opnd;
        prod_lo_q   <= cnt_q[0];
        prod_slow_q <= cnt_q[1];
        prod_up_q   <= up;
      end
      if (prod_vld_q) begin
        if (!prod_lo_q)       acc_q  <= prod_q;
        else if (prod_slow_q) slow_q <= new_level;
        else                  fast_q <= new_level;
      end
    end
  end

  assign done_o = done_q;
  assign fast_o = fast_q;
  assign slow_o = slow_q;

endmodule
`default_nettype wire

// File: hw/rtl/tsc_div.sv
// Ratio divider: Q0.16 quotient of num/den clamped to 1.0, one bit per cycle.
// Depends on tsc_pkg.
`default_nettype none
module tsc_div import tsc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  div_req_t      req_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o
);

  logic               busy_q, done_q, sat_q;
  logic [DivCntW-1:0] cnt_q;
  logic [LevelW-1:0]  rem_q, den_q;
  logic [DivSteps-1:0] quo_q;
  logic [LevelW:0]    sh;
  logic               ge;

  assign sh = {rem_q, 1'b0};
  assign ge = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DivCntW'(DivSteps - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == DivCntW'(DivSteps - 1)) busy_q <= 1'b0;
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      den_q <= req_i.den;
      sat_q <= req_i.num >= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? LevelW'(sh - {1'b0, den_q}) : sh[LevelW-1:0];
      quo_q <= {quo_q[DivSteps-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = sat_q ? OneQ16 : {1'b0, quo_q};

endmodule
`default_nettype wire

// File: hw/rtl/transient_shaper_core.sv
// Transient shaper top: config registers, sequencer, envelope RAM, gain path, output register.
// Depends on tsc_pkg, tsc_ram, tsc_env, tsc_div.
//
//  port group | dir | handshake            | payload
//  cfg        | in  | cfg_we_i             | cfg_addr_i, cfg_wdata_i
//  in         | in  | in_valid_i/in_ready_o | sample_in_i, channel_i
//  out        | out | out_valid_o/out_ready_i | sample_out_o, clipped_o
//
// One word at a time, in this order from one accept to the next: accept, RAM read,
// envelope multiply sequence, two divisions, gain steps, output load.
// A channel at or above MaxChannels skips to the output load and passes through unchanged.
// Reset clears both envelope levels through per-channel valid bits.
// A stalled output holds the last stage; the next word is taken once it leaves.
`default_nettype none
module transient_shaper_core import tsc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgAddrW-1:0]       cfg_addr_i,
  input  logic [CoeffW-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] sample_in_i,
  input  logic                      channel_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] sample_out_o,
  output logic                      clipped_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StRead = 4'd1;
  localparam logic [3:0] StEnv  = 4'd2;
  localparam logic [3:0] StDivT = 4'd3;
  localparam logic [3:0] StDivS = 4'd4;
  localparam logic [3:0] StMix  = 4'd5;
  localparam logic [3:0] StDb   = 4'd6;
  localparam logic [3:0] StCorr = 4'd7;
  localparam logic [3:0] StIdx  = 4'd8;
  localparam logic [3:0] StGain = 4'd9;
  localparam logic [3:0] StMul  = 4'd10;
  localparam logic [3:0] StOut  = 4'd11;

  logic [3:0] state_q, state_d;

  env_coeff_t      coeff_q;
  logic [AmtW-1:0] atk_amt_q, sus_amt_q, atk_amt, sus_amt;

  logic signed [SampleW-1:0] x_q;
  logic [ChW-1:0]            ch_q;
  logic                      byp_q;
  logic [MaxChannels-1:0]    valid_q;

  logic            in_acc, ch_ok;
  logic [ChW-1:0]  ch_in;
  logic            ram_we;
  logic [RamW-1:0] ram_rdata;
  logic [LevelW-1:0] lv_fast, lv_slow, env_fast, env_slow, den;
  logic [SampleW-1:0] mag;

  env_req_t env_req;
  div_req_t div_req;
  logic     env_done, div_done;
  logic [QW-1:0] quo;

  logic [QW-1:0]    t_q, s_q;
  logic [MixW-1:0]  y_q;
  logic [Mix3W-1:0] y3_q;
  logic [DbW-1:0]   q0_q, db_q;
  logic [IdxW-1:0]  idx_q;
  logic [GainW-1:0] gain_q;
  logic signed [SampleW+GainW:0] p_q;

  logic [Mix3W-1:0] y3, rem25;
  logic [Mix3W+31:0] prod25;
  logic [DbW+GainTableBits:0] vsum;
  logic [VW-1:0]    v;
  logic [VW+15:0]   v3;
  logic [VW-2:0]    idx_raw;
  logic signed [SampleW+GainW-12:0] qv;
  logic signed [SampleW-1:0] res;
  logic             clip, out_load;

  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_sample_q;
  logic                      out_clip_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q   <= '{fast_atk: FastAtkRst, fast_rel: FastRelRst,
                     slow_atk: SlowAtkRst, slow_rel: SlowRelRst};
      atk_amt_q <= '0;
      sus_amt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegFastAtk: coeff_q.fast_atk <= cfg_wdata_i;
        RegFastRel: coeff_q.fast_rel <= cfg_wdata_i;
        RegSlowAtk: coeff_q.slow_atk <= cfg_wdata_i;
        RegSlowRel: coeff_q.slow_rel <= cfg_wdata_i;
        RegAtkAmt:  atk_amt_q <= cfg_wdata_i[AmtW-1:0];
        RegSusAmt:  sus_amt_q <= cfg_wdata_i[AmtW-1:0];
        default: ;
      endcase
    end
  end

  assign atk_amt = (atk_amt_q > AmtMax) ? AmtMax : atk_amt_q;
  assign sus_amt = (sus_amt_q > AmtMax) ? AmtMax : sus_amt_q;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ch_ok      = {31'b0, channel_i} < MaxChannels;
  assign ch_in      = ChW'(channel_i);

  // envelope store
  assign ram_we = (state_q == StEnv) && env_done;

  tsc_ram #(.Width(RamW), .Depth(MaxChannels)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_q),
    .wdata_i ({env_fast, env_slow}),
    .re_i    (in_acc),
    .raddr_i (ch_in),
    .rdata_o (ram_rdata)
  );

  assign lv_fast = valid_q[ch_q] ? ram_rdata[RamW-1:LevelW] : '0;
  assign lv_slow = valid_q[ch_q] ? ram_rdata[LevelW-1:0]    : '0;
  assign mag     = x_q[SampleW-1] ? SampleW'(-x_q) : x_q;

  always_comb begin
    env_req.start = (state_q == StRead);
    env_req.mag   = mag;
    env_req.fast  = lv_fast;
    env_req.slow  = lv_slow;
  end

  tsc_env u_env (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (env_req),
    .coeff_i (coeff_q),
    .done_o  (env_done),
    .fast_o  (env_fast),
    .slow_o  (env_slow)
  );

  assign den = (env_slow > FloorQ47) ? env_slow : FloorQ47;

  always_comb begin
    div_req.den   = den;
    div_req.start = 1'b0;
    div_req.num   = '0;
    if (state_q == StEnv && env_done) begin
      div_req.start = 1'b1;
      div_req.num   = (env_fast > env_slow) ? (env_fast - env_slow) : '0;
    end else if (state_q == StDivT && div_done) begin
      div_req.start = 1'b1;
      div_req.num   = (env_fast < env_slow) ? env_fast : env_slow;
    end
  end

  tsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // gain path
  assign y3      = {2'b0, y_q} + {1'b0, y_q, 1'b0};
  assign prod25  = y3 * Recip25;
  assign rem25   = y3_q - Mix3W'(q0_q) * Mix3W'(25);
  assign vsum    = {db_q, {GainTableBits{1'b0}}} + (DbW+GainTableBits+1)'(3 << 18);
  assign v       = VW'(vsum >> 19);
  assign v3      = v * Recip3;
  assign idx_raw = v3[VW+15:17];

  assign qv   = (SampleW+GainW-11)'(p_q >>> 16);
  assign clip = (qv > (SampleW+GainW-11)'(8388607)) || (qv < -(SampleW+GainW-11)'(8388608));
  assign res  = (qv > (SampleW+GainW-11)'(8388607)) ? 24'sh7FFFFF :
                (qv < -(SampleW+GainW-11)'(8388608)) ? 24'sh800000 : qv[SampleW-1:0];

  assign out_load = (state_q == StOut) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc) state_d = ch_ok ? StRead : StOut;
      StRead: state_d = StEnv;
      StEnv:  if (env_done) state_d = StDivT;
      StDivT: if (div_done) state_d = StDivS;
      StDivS: if (div_done) state_d = StMix;
      StMix:  state_d = StDb;
      StDb:   state_d = StCorr;
      StCorr: state_d = StIdx;
      StIdx:  state_d = StGain;
      StGain: state_d = StMul;
      StMul:  state_d = StOut;
      StOut:  if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) valid_q[ch_q] <= 1'b1;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q   <= sample_in_i;
      ch_q  <= ch_in;
      byp_q <= !ch_ok;
    end
    if (state_q == StDivT && div_done) t_q <= quo;
    if (state_q == StDivS && div_done) s_q <= quo;
    if (state_q == StMix)
      y_q <= MixW'(atk_amt) * MixW'(t_q) + MixW'(sus_amt) * MixW'(s_q);
    if (state_q == StDb) begin
      y3_q <= y3;
      q0_q <= prod25[DbW+31:32];
    end
    if (state_q == StCorr) db_q <= (rem25 >= Mix3W'(25)) ? (q0_q + 1'b1) : q0_q;
    if (state_q == StIdx)
      idx_q <= (idx_raw > (VW-1)'(1 << GainTableBits)) ? IdxW'(1 << GainTableBits)
                                                         : IdxW'(idx_raw);
    if (state_q == StGain) gain_q <= GainTable[idx_q];
    if (state_q == StMul)  p_q <= x_q * $signed({1'b0, gain_q}) + 45'sd32768;
    if (out_load) begin
      out_sample_q <= byp_q ? x_q  : res;
      out_clip_q   <= byp_q ? 1'b0 : clip;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign clipped_o    = out_clip_q;

endmodule
`default_nettype wire

// File: hw/rtl/tsc_checker.sv
// Port-level checks for the transient shaper, bound to the top level.
// Depends on tsc_pkg and transient_shaper_core.
`default_nettype none
module tsc_checker import tsc_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [SampleW-1:0] sample_out_o,
  input logic                      clipped_o
);

  // one word in flight: no new word right after one is taken
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("word accepted back to back");

  // a clipped word carries a rail value
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (sample_out_o == 24'sh7FFFFF || sample_out_o == 24'sh800000))
    else $error("clipped word not at a rail");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sample_out_o)))
    else $error("stalled output word changed");

  // no output word becomes valid while the core stays idle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_ready_o) && in_ready_o && !$past(out_valid_o)) |-> !out_valid_o)
    else $error("output word without input");

endmodule

bind transient_shaper_core tsc_checker u_tsc_checker (.*);
`default_nettype wire
